// ===== rtl/core/line_of_sight_visibility_cost_defines.svh =====
// Assertion macros shared by the line-of-sight visibility cost RTL.
// Depends on nothing; expects signals clk and rst_n in the using module.
`ifndef LINE_OF_SIGHT_VISIBILITY_COST_DEFINES_SVH
`define LINE_OF_SIGHT_VISIBILITY_COST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LOSVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("losvc assertion failed");

// Next-cycle implication, checked outside reset.
`define LOSVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("losvc assertion failed");

`endif

// ===== rtl/core/losvc_pkg.sv =====
// Shared constants and types for the line-of-sight visibility cost block.
// Depends on nothing.
`default_nettype none

package losvc_pkg;

  localparam int GRID_SIDE  = 256;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);
  localparam int MAX_OBS    = 8;
  localparam int OBS_IW     = $clog2(MAX_OBS);

  // Input operation codes.
  localparam logic [1:0] MODE_WR_CELL = 2'd0;
  localparam logic [1:0] MODE_WR_OBS  = 2'd1;
  localparam logic [1:0] MODE_EVAL    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LAYER_ENABLED  = 2'd0;
  localparam logic [1:0] CFG_VIEW_RANGE     = 2'd1;
  localparam logic [1:0] CFG_WALL_THRESHOLD = 2'd2;

  localparam logic [7:0] COST_UNKNOWN = 8'd255;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_RD     = 13'b0000000000010,
    ST_OBS    = 13'b0000000000100,
    ST_SQX    = 13'b0000000001000,
    ST_SQY    = 13'b0000000010000,
    ST_RANGE  = 13'b0000000100000,
    ST_SQRT   = 13'b0000001000000,
    ST_WSETUP = 13'b0000010000000,
    ST_WALK   = 13'b0000100000000,
    ST_CNUM   = 13'b0001000000000,
    ST_CMUL   = 13'b0010000000000,
    ST_DIV    = 13'b0100000000000,
    ST_NEXT   = 13'b1000000000000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/losvc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module losvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/line_of_sight_visibility_cost.sv =====
// Line-of-sight visibility cost block, top level.
// Depends on losvc_pkg, losvc_ram and line_of_sight_visibility_cost_defines.svh.
//
// Usage:
// The input channel (in_valid/in_ready) carries one operation per transfer:
// mode 0 writes a grid cell, mode 1 writes an observer slot, mode 2 evaluates
// a cell; mode 3 is dropped. Only mode 2 returns a result, on the output
// channel (out_valid/out_ready) as out_result_cost.
// Writes complete in the cycle of the transfer. After an evaluate transfer the
// sequencer fetches the stored cost, then visits each observer slot: an unused
// slot is skipped, one out of range ends after the distance check, and any
// other runs the iterative square root, one grid memory read per line step and
// the bit-serial divider.
// One operation is in work at a time; in_ready is high while the sequencer is
// idle, even while a finished result waits in the output register.
// If the receiver stalls, a second result waits in the sequencer until the
// output register frees. Reset clears the observer valid bits and all control and
// loads the configuration defaults; the grid memory is undefined until written.
// Configuration writes (cfg_we) take effect at once and belong to idle time.
`include "line_of_sight_visibility_cost_defines.svh"
`default_nettype none

module line_of_sight_visibility_cost
  import losvc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_cell_x,
  input  wire logic [7:0]  in_cell_y,
  input  wire logic [7:0]  in_cell_value,
  input  wire logic [2:0]  in_observer_slot,
  input  wire logic [11:0] in_observer_x_q4,
  input  wire logic [11:0] in_observer_y_q4,
  input  wire logic        in_observer_valid,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_result_cost,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // Configuration registers.
  logic        enabled_r;
  logic [11:0] range_r;
  logic [7:0]  thr_r;

  // Observer table.
  logic [MAX_OBS-1:0] obs_v_r;
  logic [11:0]        obs_x_r [MAX_OBS];
  logic [11:0]        obs_y_r [MAX_OBS];

  // Evaluation datapath.
  logic [7:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [7:0]  best_r, best_nxt;
  logic [OBS_IW-1:0] k_r, k_nxt;
  logic [23:0] rr_r, rr_nxt;
  logic signed [12:0] dxs_r, dxs_nxt, dys_r, dys_nxt;
  logic [25:0] d2_r, d2_nxt;
  logic [33:0] sq_val_r, sq_val_nxt;
  logic [19:0] sq_rem_r, sq_rem_nxt;
  logic [16:0] sq_root_r, sq_root_nxt;
  logic [4:0]  sq_cnt_r, sq_cnt_nxt;
  logic        steep_r, steep_nxt, xinc_r, xinc_nxt, yinc_r, yinc_nxt;
  logic [7:0]  wx_r, wx_nxt, wy_r, wy_nxt, wdx_r, wdx_nxt, wdy_r, wdy_nxt;
  logic signed [10:0] pk_r, pk_nxt;
  logic [8:0]  wcnt_r, wcnt_nxt;
  logic        issue_done_r, issue_done_nxt;
  logic        chk_v_r, chk_v_nxt, chk_last_r, chk_last_nxt;
  logic [20:0] num_r, num_nxt, den_r, den_nxt;
  logic [28:0] rem_r, rem_nxt;
  logic [7:0]  q_r, q_nxt;
  logic [2:0]  div_cnt_r, div_cnt_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_cost_r, out_cost_nxt;

  // Grid memory ports.
  logic               ram_we;
  logic [GRID_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  logic in_xfer;
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_result_cost = out_cost_r;

  assign ram_we = in_xfer && (in_mode == MODE_WR_CELL);

  losvc_ram #(.WIDTH(8), .DEPTH(GRID_DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_cell_y, in_cell_x}),
    .wdata (in_cell_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration and observer table writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      range_r   <= 12'd640;
      thr_r     <= 8'd252;
      obs_v_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LAYER_ENABLED:  enabled_r <= cfg_wdata[0];
          CFG_VIEW_RANGE:     range_r   <= cfg_wdata;
          CFG_WALL_THRESHOLD: thr_r     <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_xfer && (in_mode == MODE_WR_OBS)) begin
        obs_v_r[in_observer_slot] <= in_observer_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_mode == MODE_WR_OBS)) begin
      obs_x_r[in_observer_slot] <= in_observer_x_q4;
      obs_y_r[in_observer_slot] <= in_observer_y_q4;
    end
  end

  // Combinational helpers for the sequencer.
  logic [11:0] ox, oy;
  logic [7:0]  obx, oby, adx, ady;
  logic [19:0] sq_rem2, sq_trial;
  logic [16:0] inv;
  logic [28:0] dsh;
  logic        div_ge;
  logic [15:0] r8;

  assign ox  = obs_x_r[k_r];
  assign oy  = obs_y_r[k_r];
  assign obx = ox[11:4];
  assign oby = oy[11:4];
  assign adx = (cx_r > obx) ? cx_r - obx : obx - cx_r;
  assign ady = (cy_r > oby) ? cy_r - oby : oby - cy_r;
  assign sq_rem2  = {sq_rem_r[17:0], sq_val_r[33:32]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign r8  = {range_r, 4'h0};
  assign inv = {1'b0, r8} - sq_root_r;
  assign dsh = {8'h00, den_r} << div_cnt_r;
  assign div_ge = (rem_r >= dsh);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    best_nxt       = best_r;
    k_nxt          = k_r;
    rr_nxt         = rr_r;
    dxs_nxt        = dxs_r;
    dys_nxt        = dys_r;
    d2_nxt         = d2_r;
    sq_val_nxt     = sq_val_r;
    sq_rem_nxt     = sq_rem_r;
    sq_root_nxt    = sq_root_r;
    sq_cnt_nxt     = sq_cnt_r;
    steep_nxt      = steep_r;
    xinc_nxt       = xinc_r;
    yinc_nxt       = yinc_r;
    wx_nxt         = wx_r;
    wy_nxt         = wy_r;
    wdx_nxt        = wdx_r;
    wdy_nxt        = wdy_r;
    pk_nxt         = pk_r;
    wcnt_nxt       = wcnt_r;
    issue_done_nxt = issue_done_r;
    chk_v_nxt      = 1'b0;
    chk_last_nxt   = 1'b0;
    num_nxt        = num_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_cost_nxt   = out_cost_r;
    ram_raddr      = {in_cell_y, in_cell_x};

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_mode == MODE_EVAL)) begin
          cx_nxt    = in_cell_x;
          cy_nxt    = in_cell_y;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        best_nxt  = ram_rdata;
        k_nxt     = '0;
        rr_nxt    = range_r * range_r;
        den_nxt   = 21'(r8) * 21'd20;
        if ((ram_rdata == COST_UNKNOWN) || !enabled_r) begin
          state_nxt = ST_NEXT;
          k_nxt     = OBS_IW'(MAX_OBS - 1);
        end else begin
          state_nxt = ST_OBS;
        end
      end
      ST_OBS: begin
        dxs_nxt = $signed({1'b0, cx_r, 4'h8}) - $signed({1'b0, ox});
        dys_nxt = $signed({1'b0, cy_r, 4'h8}) - $signed({1'b0, oy});
        state_nxt = (obs_v_r[k_r] && (range_r != '0)) ? ST_SQX : ST_NEXT;
      end
      ST_SQX: begin
        d2_nxt    = 26'($unsigned(26'(dxs_r) * 26'(dxs_r)));
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        d2_nxt    = d2_r + 26'($unsigned(26'(dys_r) * 26'(dys_r)));
        state_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        // Equal distance gives a zero inverse distance and no cost.
        sq_val_nxt  = {d2_r, 8'h00};
        sq_rem_nxt  = '0;
        sq_root_nxt = '0;
        sq_cnt_nxt  = '0;
        state_nxt   = ({d2_r} >= {2'b00, rr_r}) ? ST_NEXT : ST_SQRT;
      end
      ST_SQRT: begin
        // One result bit per cycle of the restoring square root.
        sq_val_nxt = {sq_val_r[31:0], 2'b00};
        if (sq_rem2 >= sq_trial) begin
          sq_rem_nxt  = sq_rem2 - sq_trial;
          sq_root_nxt = {sq_root_r[15:0], 1'b1};
        end else begin
          sq_rem_nxt  = sq_rem2;
          sq_root_nxt = {sq_root_r[15:0], 1'b0};
        end
        sq_cnt_nxt = sq_cnt_r + 5'd1;
        if (sq_cnt_r == 5'd16) begin
          state_nxt = ST_WSETUP;
        end
      end
      ST_WSETUP: begin
        steep_nxt = (adx < ady);
        if (adx < ady) begin
          wx_nxt   = cy_r;
          wy_nxt   = cx_r;
          wdx_nxt  = ady;
          wdy_nxt  = adx;
          xinc_nxt = (cy_r < oby);
          yinc_nxt = (cx_r < obx);
          pk_nxt   = $signed({2'b00, adx, 1'b0}) - $signed({3'b000, ady});
        end else begin
          wx_nxt   = cx_r;
          wy_nxt   = cy_r;
          wdx_nxt  = adx;
          wdy_nxt  = ady;
          xinc_nxt = (cx_r < obx);
          yinc_nxt = (cy_r < oby);
          pk_nxt   = $signed({2'b00, ady, 1'b0}) - $signed({3'b000, adx});
        end
        wcnt_nxt       = '0;
        issue_done_nxt = 1'b0;
        state_nxt      = ST_WALK;
      end
      ST_WALK: begin
        // Issue one grid read per cycle and check the previous one.
        ram_raddr = steep_r ? {wx_r, wy_r} : {wy_r, wx_r};
        if (!issue_done_r) begin
          chk_v_nxt    = 1'b1;
          chk_last_nxt = (wcnt_r == {1'b0, wdx_r});
          issue_done_nxt = (wcnt_r == {1'b0, wdx_r});
          wcnt_nxt     = wcnt_r + 9'd1;
          wx_nxt       = xinc_r ? wx_r + 8'd1 : wx_r - 8'd1;
          if (pk_r < 0) begin
            pk_nxt = pk_r + $signed({2'b00, wdy_r, 1'b0});
          end else begin
            wy_nxt = yinc_r ? wy_r + 8'd1 : wy_r - 8'd1;
            pk_nxt = pk_r + $signed({2'b00, wdy_r, 1'b0})
                          - $signed({2'b00, wdx_r, 1'b0});
          end
        end
        if (chk_v_r) begin
          if (ram_rdata > thr_r) begin
            state_nxt      = ST_NEXT;
            issue_done_nxt = 1'b1;
            chk_v_nxt      = 1'b0;
          end else if (chk_last_r) begin
            state_nxt = ST_CNUM;
          end
        end
      end
      ST_CNUM: begin
        num_nxt = {4'b0, inv} * 21'd20 + {5'b0, r8};
        if (num_nxt > den_r) begin
          num_nxt = den_r;
        end
        state_nxt = ST_CMUL;
      end
      ST_CMUL: begin
        rem_nxt     = {8'b0, num_r} * 29'd254;
        q_nxt       = '0;
        div_cnt_nxt = 3'd7;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        // Bit-serial restoring divide, quotient fits in eight bits.
        q_nxt = {q_r[6:0], div_ge};
        if (div_ge) begin
          rem_nxt = rem_r - dsh;
        end
        div_cnt_nxt = div_cnt_r - 3'd1;
        if (div_cnt_r == 3'd0) begin
          if (q_nxt > best_r) begin
            best_nxt = q_nxt;
          end
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (k_r == OBS_IW'(MAX_OBS - 1)) begin
          if (!out_valid_r || out_ready) begin
            out_valid_nxt = 1'b1;
            out_cost_nxt  = best_r;
            state_nxt     = ST_IDLE;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_OBS;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      chk_v_r      <= 1'b0;
      chk_last_r   <= 1'b0;
      issue_done_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      chk_v_r      <= chk_v_nxt;
      chk_last_r   <= chk_last_nxt;
      issue_done_r <= issue_done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    best_r    <= best_nxt;
    k_r       <= k_nxt;
    rr_r      <= rr_nxt;
    dxs_r     <= dxs_nxt;
    dys_r     <= dys_nxt;
    d2_r      <= d2_nxt;
    sq_val_r  <= sq_val_nxt;
    sq_rem_r  <= sq_rem_nxt;
    sq_root_r <= sq_root_nxt;
    sq_cnt_r  <= sq_cnt_nxt;
    steep_r   <= steep_nxt;
    xinc_r    <= xinc_nxt;
    yinc_r    <= yinc_nxt;
    wx_r      <= wx_nxt;
    wy_r      <= wy_nxt;
    wdx_r     <= wdx_nxt;
    wdy_r     <= wdy_nxt;
    pk_r      <= pk_nxt;
    wcnt_r    <= wcnt_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    div_cnt_r <= div_cnt_nxt;
    out_cost_r <= out_cost_nxt;
  end

  // An evaluate transfer starts the stored-cost fetch.
  `LOSVC_ASSERT_NEXT(a_eval_fetch, in_xfer && (in_mode == MODE_EVAL), state_r == ST_RD)
  // A wall seen on the line ends that observer's walk.
  `LOSVC_ASSERT_NEXT(a_wall_stops, state_r == ST_WALK && chk_v_r && ram_rdata > thr_r, state_r == ST_NEXT)
  // A new result is loaded only when the last observer slot is done.
  `LOSVC_ASSERT_NOW(a_result_src, $rose(out_valid_r), $past(state_r == ST_NEXT))

endmodule

`default_nettype wire

// ===== test/line_of_sight_visibility_cost_checker.sv =====
// Checker for the line-of-sight visibility cost block: watches both channels and
// the configuration port, predicts each cost and compares it. Depends on losvc_pkg.
`timescale 1ns / 100ps

module line_of_sight_visibility_cost_checker
  import losvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_cell_x,
  input  logic [7:0]  in_cell_y,
  input  logic [7:0]  in_cell_value,
  input  logic [2:0]  in_observer_slot,
  input  logic [11:0] in_observer_x_q4,
  input  logic [11:0] in_observer_y_q4,
  input  logic        in_observer_valid,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_result_cost,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  // Local copy of the block's state and registers.
  logic [7:0]  cost_grid [GRID_DEPTH];
  logic        watcher_valid [MAX_OBS];
  logic [11:0] watcher_x [MAX_OBS];
  logic [11:0] watcher_y [MAX_OBS];
  logic        layer_on;
  logic [11:0] range_q4;
  logic [7:0]  wall_level;
  logic [7:0]  expected_costs [$];

  // Floor of the square root, one result bit per pass.
  function automatic longint root_floor(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Walks the Bresenham line, both ends included, and looks for a wall.
  function automatic bit line_has_wall(int ax, int ay, int bx, int by);
    int dx;
    int dy;
    int t;
    int x;
    int y;
    int pk;
    int cx;
    int cy;
    bit steep;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    steep = dx < dy;
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
      t = dx; dx = dy; dy = t;
    end
    x = ax;
    y = ay;
    pk = 2 * dy - dx;
    for (int i = 0; i <= dx; i++) begin
      cx = steep ? y : x;
      cy = steep ? x : y;
      if (cx >= 0 && cy >= 0 && cx < GRID_SIDE && cy < GRID_SIDE &&
          cost_grid[cy * GRID_SIDE + cx] > wall_level)
        return 1'b1;
      x += (ax < bx) ? 1 : -1;
      if (pk < 0) begin
        pk += 2 * dy;
      end else begin
        y += (ay < by) ? 1 : -1;
        pk += 2 * dy - 2 * dx;
      end
    end
    return 1'b0;
  endfunction

  // Cost of one cell: stored cost raised to the highest cost of any observer in range with a clear view.
  function automatic logic [7:0] predict_cost(int cx, int cy);
    logic [7:0] best;
    longint r;
    longint r8;
    longint px;
    longint py;
    longint dx;
    longint dy;
    longint d2;
    longint d8;
    longint inv;
    longint num;
    longint c;
    best = cost_grid[cy * GRID_SIDE + cx];
    if (best == COST_UNKNOWN || !layer_on) return best;
    r = range_q4;
    r8 = r * 16;
    px = cx * 16 + 8;
    py = cy * 16 + 8;
    for (int k = 0; k < MAX_OBS; k++) begin
      if (!watcher_valid[k] || r == 0) continue;
      dx = px - longint'(watcher_x[k]);
      dy = py - longint'(watcher_y[k]);
      d2 = dx * dx + dy * dy;
      if (d2 > r * r) continue;
      d8 = root_floor(d2 * 256);
      inv = (d8 >= r8) ? 0 : r8 - d8;
      if (inv == 0) continue;
      if (line_has_wall(cx, cy, watcher_x[k] >> 4, watcher_y[k] >> 4)) continue;
      num = 20 * inv + r8;
      if (num > 20 * r8) num = 20 * r8;
      c = (254 * num) / (20 * r8);
      if (c > best) best = c[7:0];
    end
    return best;
  endfunction

  // Results are compared before the transfer of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_costs.delete();
      for (int k = 0; k < MAX_OBS; k++) watcher_valid[k] = 1'b0;
      layer_on = 1'b1;
      range_q4 = 12'd640;
      wall_level = 8'd252;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_costs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: cost %0d", out_result_cost);
        end else begin
          if (out_result_cost !== expected_costs[0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cost mismatch: expected %0d, got %0d",
                       expected_costs[0], out_result_cost);
          end
          void'(expected_costs.pop_front());
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LAYER_ENABLED:  layer_on = cfg_wdata[0];
          CFG_VIEW_RANGE:     range_q4 = cfg_wdata;
          CFG_WALL_THRESHOLD: wall_level = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_mode)
          MODE_WR_CELL: cost_grid[{in_cell_y, in_cell_x}] = in_cell_value;
          MODE_WR_OBS: begin
            watcher_valid[in_observer_slot] = in_observer_valid;
            watcher_x[in_observer_slot] = in_observer_x_q4;
            watcher_y[in_observer_slot] = in_observer_y_q4;
          end
          MODE_EVAL:
            expected_costs = {expected_costs, predict_cost(in_cell_x, in_cell_y)};
          default: ;
        endcase
      end
    end
    pending = expected_costs.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the line-of-sight visibility cost testbench: clock, reset, stimulus and
// verdict. Depends on losvc_pkg, the block and line_of_sight_visibility_cost_checker.
`timescale 1ns / 100ps

module testbench;
  import losvc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 25000;
  // All traffic stays in one square region of the grid, written in full first.
  localparam int REG_LO = 246;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [7:0]  in_cell_x;
  logic [7:0]  in_cell_y;
  logic [7:0]  in_cell_value;
  logic [2:0]  in_observer_slot;
  logic [11:0] in_observer_x_q4;
  logic [11:0] in_observer_y_q4;
  logic        in_observer_valid;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_result_cost;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          quiet;
  bit          hold_req;
  int          hot_x;
  int          hot_y;

  line_of_sight_visibility_cost i_dut (.*);

  line_of_sight_visibility_cost_checker i_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial out_ready = 1'b0;
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_ready <= 1'b0;
      repeat (2000) @(negedge clk);
      hold_req = 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[line_of_sight_visibility_cost] ERROR");
      $finish;
    end
  end

  // Offers one operation and returns at the edge of its transfer.
  task automatic send_op(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                         logic [7:0] value, logic [2:0] slot, logic [11:0] ox,
                         logic [11:0] oy, logic ov);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_cell_x <= x;
    in_cell_y <= y;
    in_cell_value <= value;
    in_observer_slot <= slot;
    in_observer_x_q4 <= ox;
    in_observer_y_q4 <= oy;
    in_observer_valid <= ov;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cell(int x, int y, int value);
    send_op(MODE_WR_CELL, 8'(x), 8'(y), 8'(value), 3'($urandom), 12'($urandom),
            12'($urandom), 1'($urandom));
  endtask

  task automatic write_watcher(int slot, int ox, int oy, bit ov);
    send_op(MODE_WR_OBS, 8'($urandom), 8'($urandom), 8'($urandom), 3'(slot),
            12'(ox), 12'(oy), ov);
  endtask

  task automatic eval_cell(int x, int y);
    send_op(MODE_EVAL, 8'(x), 8'(y), 8'($urandom), 3'($urandom), 12'($urandom),
            12'($urandom), 1'($urandom));
  endtask

  // Drops valid and waits until every expected cost has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] index, int value);
    drain();
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= 12'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A coordinate close to h, kept inside the written region.
  function automatic int near(int h);
    int v;
    v = h + int'($urandom_range(0, 10)) - 5;
    return (v < REG_LO) ? REG_LO : (v > 255) ? 255 : v;
  endfunction

  function automatic int random_cost();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(0, 200);
    if (pick < 95) return $urandom_range(201, 254);
    return 255;
  endfunction

  // Mostly local traffic around a hot spot, some noise anywhere in the region, invalid observers anywhere.
  task automatic random_phase(int count);
    int pick;
    hot_x = $urandom_range(REG_LO, 255);
    hot_y = $urandom_range(REG_LO, 255);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)
        write_watcher($urandom_range(0, 7), near(hot_x) * 16 + $urandom_range(0, 15),
                      near(hot_y) * 16 + $urandom_range(0, 15),
                      $urandom_range(0, 5) != 0);
      else if (pick < 20)
        write_watcher($urandom_range(0, 7), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), 1'b0);
      else if (pick < 45)
        write_cell(near(hot_x), near(hot_y), random_cost());
      else if (pick < 85)
        eval_cell(near(hot_x), near(hot_y));
      else if (pick < 95)
        eval_cell($urandom_range(REG_LO, 255), $urandom_range(REG_LO, 255));
      else
        send_op(MODE_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom),
                12'($urandom), 12'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_WR_CELL;
    in_cell_x = '0;
    in_cell_y = '0;
    in_cell_value = '0;
    in_observer_slot = '0;
    in_observer_x_q4 = '0;
    in_observer_y_q4 = '0;
    in_observer_valid = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LAYER_ENABLED;
    cfg_wdata = '0;
    quiet = 1'b1;
    hold_req = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the region first; every line between two of its cells stays inside.
    for (int y = REG_LO; y < GRID_SIDE; y++)
      for (int x = REG_LO; x < GRID_SIDE; x++)
        write_cell(x, y, random_cost());
    quiet = 1'b0;

    // Directed: corners, unknown cells, a wall, observers at the region edges.
    write_watcher(0, 4095, 4095, 1'b1);
    write_watcher(7, REG_LO * 16, REG_LO * 16, 1'b1);
    write_watcher(3, 4095, REG_LO * 16, 1'b0);
    write_cell(255, 255, 0);
    write_cell(254, 254, 5);
    write_cell(REG_LO, REG_LO, 255);
    write_cell(REG_LO + 1, 255, 10);
    write_cell(255, REG_LO, 0);
    eval_cell(255, 255);
    eval_cell(254, 254);
    eval_cell(REG_LO, REG_LO);
    eval_cell(REG_LO + 1, 255);
    eval_cell(255, REG_LO);
    write_cell(250, 250, 254);
    write_cell(251, 251, 0);
    write_cell(248, 248, 0);
    eval_cell(248, 248);
    write_watcher(1, REG_LO * 16 + 8, 255 * 16 + 8, 1'b1);
    write_cell(250, 255, 0);
    eval_cell(250, 255);
    send_op(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 3'd7, 12'hFFF, 12'hFFF, 1'b1);
    eval_cell(255, REG_LO + 2);

    // Defaults written explicitly, then settings including the extremes.
    set_reg(CFG_LAYER_ENABLED, 1);
    set_reg(CFG_VIEW_RANGE, 640);
    set_reg(CFG_WALL_THRESHOLD, 252);
    random_phase(25);

    // Long receiver hold-off while evaluations keep coming.
    set_reg(CFG_VIEW_RANGE, 4095);
    set_reg(CFG_WALL_THRESHOLD, 254);
    @(negedge clk);
    hold_req = 1'b1;
    for (int n = 0; n < 6; n++) eval_cell(near(hot_x), near(hot_y));
    random_phase(25);

    set_reg(CFG_VIEW_RANGE, 16);
    set_reg(CFG_WALL_THRESHOLD, 0);
    random_phase(15);
    drain();
    random_phase(15);

    set_reg(CFG_LAYER_ENABLED, 0);
    random_phase(25);

    set_reg(CFG_LAYER_ENABLED, 1);
    set_reg(CFG_VIEW_RANGE, 0);
    set_reg(CFG_WALL_THRESHOLD, 255);
    random_phase(20);

    // Last part without idling on either side.
    set_reg(CFG_VIEW_RANGE, 200);
    set_reg(CFG_WALL_THRESHOLD, 200);
    quiet = 1'b1;
    random_phase(40);

    drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0)
      $display("[line_of_sight_visibility_cost] OK");
    else
      $display("[line_of_sight_visibility_cost] ERROR");
    $finish;
  end

endmodule
